[sv/acs_pkg.sv]
// Shared constants and types of the accumulator machine step block.
package acs_pkg;

    localparam logic [1:0] KIND_EXEC  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [6:0] OP_READ   = 7'h0A;
    localparam logic [6:0] OP_WRITE  = 7'h0B;
    localparam logic [6:0] OP_LOAD   = 7'h14;
    localparam logic [6:0] OP_STORE  = 7'h15;
    localparam logic [6:0] OP_ADD    = 7'h1E;
    localparam logic [6:0] OP_SUB    = 7'h1F;
    localparam logic [6:0] OP_DIVIDE = 7'h20;
    localparam logic [6:0] OP_MUL    = 7'h21;
    localparam logic [6:0] OP_JUMP   = 7'h28;
    localparam logic [6:0] OP_JNEG   = 7'h29;
    localparam logic [6:0] OP_JZ     = 7'h2A;
    localparam logic [6:0] OP_HALT   = 7'h2B;
    localparam logic [6:0] OP_NEG    = 7'h40;
    localparam logic [6:0] OP_SUBC   = 7'h42;
    localparam logic [6:0] OP_MOVC   = 7'h47;

    localparam logic [15:0] MUL_LIMIT = 16'h777F;
    localparam logic [15:0] POS_MAX   = 16'h7FFF;

    // Flag bit positions: overflow, divide by zero, halt, decode error.
    localparam int F_OVF  = 0;
    localparam int F_ZDIV = 1;
    localparam int F_HALT = 2;
    localparam int F_DEC  = 3;
    localparam logic [3:0] FLAGS_RESET = 4'b0100;

    typedef struct packed {
        logic [3:0]  flags;
        logic [6:0]  operand;
        logic [6:0]  opcode;
        logic [6:0]  counter;
        logic [15:0] acc;
        logic [15:0] write_value;
        logic        write_valid;
    } t_result;

    function automatic logic cmd_known(input logic [6:0] c);
        logic ok;
        begin
            case (c)
                OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIVIDE,
                OP_MUL, OP_JUMP, OP_JNEG, OP_JZ, OP_HALT, OP_NEG, OP_SUBC,
                OP_MOVC: ok = 1'b1;
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

[sv/accumulator_cpu_step.sv]
// Accumulator machine that runs one instruction per execute item.
//
//  channel  | direction | tdata / tuser                                   | sides
//  slave    | in        | tdata: mem_address, mem_data, read_value        | tuser: kind
//  master   | out       | tdata: write_valid, write_value, acc_value,     | one per item
//           |           |   counter_value, opcode_seen, operand_seen, flags |
//
// A reset or memory write item goes straight to the output state; an execute
// item runs fetch, decode, operand read and an optional second read, and
// DIVIDE with a nonzero divisor or MUL with a nonzero accumulator also runs
// the shared 16-step restoring divider.
// The word memory has a single port with a registered read; every
// access of an item is made in turn through that port.
// Reset (i_rst_n low, synchronous) and a reset item clear the per-word valid
// bits, so the whole memory reads as zero at once with no clearing pass.
// A finished result waits in the output register; a stalled output holds the
// machine until it is taken, and no item is accepted meanwhile.
module accumulator_cpu_step #(
    parameter int MEM_WORDS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // mem_address[6:0], mem_data[22:7], read_value[39:23]
    input  logic [39:0] i_s_tdata,
    // kind[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // write_valid[0], write_value[16:1], acc_value[32:17], counter_value[39:33],
    // opcode_seen[46:40], operand_seen[53:47], overflow_flag[54],
    // zero_div_flag[55], halt_flag[56], decode_error_flag[57], zero fill
    output logic [63:0] o_m_tdata
);
    import acs_pkg::*;

    localparam int IW = $clog2(MEM_WORDS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_OPND  = 3'd3;
    localparam logic [2:0] S_ACCRD = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    // Architectural state and per-item registers.
    logic [2:0]         r_state;
    logic [15:0]        r_acc;
    logic [6:0]         r_pc;
    logic [3:0]         r_flags;
    logic [16:0]        r_rval;
    logic [6:0]         r_opc;
    logic [6:0]         r_opd;
    logic               r_wvalid;
    logic [15:0]        r_wv;
    logic signed [15:0] r_v;
    logic               r_is_mul;
    logic               r_neg;
    logic [16:0]        r_rem;
    logic [15:0]        r_quo;
    logic [15:0]        r_dvs;
    logic [3:0]         r_cnt;
    logic               r_o_valid;
    t_result            r_out;

    // Word memory with per-word valid bits.
    logic [15:0]        r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_vld;
    logic [15:0]        r_rdata;
    logic               r_rd_ok;

    logic               mem_we;
    logic [6:0]         mem_wa;
    logic [15:0]        mem_wd;
    logic               mem_re;
    logic [6:0]         mem_ra;
    logic               clr_vld;

    logic               s_acc;
    logic [1:0]         in_kind;
    logic [6:0]         in_addr;
    logic [15:0]        in_data;

    logic signed [15:0] rd_val;
    logic signed [17:0] a18;
    logic signed [17:0] v18;
    logic               acc_in_range;
    logic [15:0]        acc_mag;
    logic [15:0]        v_mag;
    logic [15:0]        word;
    logic               dec_bad;
    logic signed [17:0] add_room;
    logic signed [17:0] rv18;
    logic [16:0]        rem_sh;
    logic [17:0]        rem_diff;
    logic signed [17:0] q_signed;
    logic signed [31:0] prod;

    function automatic logic in_mem(input logic [6:0] a);
        return ({1'b0, a} < 8'(MEM_WORDS));
    endfunction

    assign in_kind = i_s_tuser;
    assign in_addr = i_s_tdata[6:0];
    assign in_data = i_s_tdata[22:7];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign rd_val       = r_rd_ok ? signed'(r_rdata) : 16'sd0;
    assign a18          = {{2{r_acc[15]}}, r_acc};
    assign v18          = {{2{rd_val[15]}}, rd_val};
    assign acc_in_range = (r_acc[15:7] == 9'd0) && in_mem(r_acc[6:0]);
    assign acc_mag      = r_acc[15] ? (16'd0 - r_acc) : r_acc;
    assign v_mag        = rd_val[15] ? (16'd0 - rd_val) : rd_val;
    assign word         = rd_val;
    assign dec_bad      = (word[15:14] != 2'b00) || !cmd_known(word[13:7]);
    assign add_room     = 18'sd32767 - a18;
    assign rv18         = {r_rval[16], r_rval};

    // One restoring divider step.
    assign rem_sh   = {r_rem[15:0], r_quo[15]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign q_signed = r_neg ? (18'sd0 - signed'({2'b00, r_quo})) : signed'({2'b00, r_quo});
    assign prod     = r_acc * r_v;

    // Memory port control.
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = 7'd0;
        mem_wd  = 16'd0;
        mem_re  = 1'b0;
        mem_ra  = 7'd0;
        clr_vld = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && in_kind == KIND_WRITE) begin
                    mem_we = 1'b1;
                    mem_wa = in_addr;
                    mem_wd = in_data;
                end
                if (s_acc && in_kind == KIND_RESET) begin
                    clr_vld = 1'b1;
                end
            end
            S_FETCH: begin
                // The fetched word is held in the read register through decode.
                mem_re = 1'b1;
                mem_ra = r_pc;
            end
            S_DEC: begin
                mem_re = 1'b1;
                mem_ra = word[6:0];
            end
            S_OPND: begin
                case (r_opc)
                    OP_READ: begin
                        mem_we = (rv18 <= 18'sd32767);
                        mem_wa = r_opd;
                        mem_wd = r_rval[15:0];
                    end
                    OP_STORE: begin
                        mem_we = 1'b1;
                        mem_wa = r_opd;
                        mem_wd = r_acc;
                    end
                    OP_MOVC: begin
                        mem_we = acc_in_range;
                        mem_wa = r_acc[6:0];
                        mem_wd = rd_val;
                    end
                    OP_SUBC: begin
                        mem_re = acc_in_range;
                        mem_ra = r_acc[6:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && in_mem(mem_wa)) begin
            r_mem[mem_wa[IW-1:0]] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_vld) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (mem_we && in_mem(mem_wa)) begin
                r_vld[mem_wa[IW-1:0]] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_ok <= in_mem(mem_ra) && r_vld[mem_ra[IW-1:0]];
            end else begin
                r_rd_ok <= 1'b0;
            end
        end
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= 16'd0;
            r_pc      <= 7'd0;
            r_flags   <= FLAGS_RESET;
            r_cnt     <= 4'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_m_tready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_rval   <= i_s_tdata[39:23];
                        r_wvalid <= 1'b0;
                        r_wv     <= 16'd0;
                        r_opc    <= 7'd0;
                        r_opd    <= 7'd0;
                        if (in_kind == KIND_EXEC) begin
                            r_state <= S_FETCH;
                        end else begin
                            r_state <= S_OUT;
                        end
                        if (in_kind == KIND_RESET) begin
                            r_acc   <= 16'd0;
                            r_pc    <= 7'd0;
                            r_flags <= FLAGS_RESET;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_opc <= word[13:7];
                    r_opd <= word[6:0];
                    if (dec_bad) begin
                        r_flags[F_DEC]  <= 1'b1;
                        r_flags[F_HALT] <= 1'b1;
                        r_pc            <= 7'd0;
                        r_state         <= S_OUT;
                    end else begin
                        r_state <= S_OPND;
                    end
                end
                S_OPND: begin
                    r_v     <= rd_val;
                    r_state <= S_OUT;
                    case (r_opc)
                        OP_READ: begin
                            if (rv18 > 18'sd32767) begin
                                r_flags[F_OVF]  <= 1'b1;
                                r_flags[F_HALT] <= 1'b1;
                                r_pc            <= 7'd0;
                            end else begin
                                r_pc <= r_pc + 7'd1;
                            end
                        end
                        OP_WRITE: begin
                            r_wvalid <= 1'b1;
                            r_wv     <= rd_val;
                            r_pc     <= r_pc + 7'd1;
                        end
                        OP_LOAD: begin
                            r_acc <= rd_val;
                            r_pc  <= r_pc + 7'd1;
                        end
                        OP_ADD: begin
                            if (add_room < v18) begin
                                r_flags[F_OVF]  <= 1'b1;
                                r_flags[F_HALT] <= 1'b1;
                                r_pc            <= 7'd0;
                            end else begin
                                r_acc <= r_acc + rd_val;
                                r_pc  <= r_pc + 7'd1;
                            end
                        end
                        OP_SUB: begin
                            r_acc <= r_acc - rd_val;
                            r_pc  <= r_pc + 7'd1;
                        end
                        OP_DIVIDE: begin
                            if (rd_val == 16'sd0) begin
                                r_flags[F_ZDIV] <= 1'b1;
                                r_flags[F_HALT] <= 1'b1;
                                r_pc            <= 7'd0;
                            end else begin
                                r_is_mul <= 1'b0;
                                r_neg    <= r_acc[15] ^ rd_val[15];
                                r_rem    <= 17'd0;
                                r_quo    <= acc_mag;
                                r_dvs    <= v_mag;
                                r_state  <= S_DIV;
                            end
                        end
                        OP_MUL: begin
                            if (r_acc == 16'd0) begin
                                r_pc <= r_pc + 7'd1;
                            end else begin
                                r_is_mul <= 1'b1;
                                r_neg    <= r_acc[15];
                                r_rem    <= 17'd0;
                                r_quo    <= MUL_LIMIT;
                                r_dvs    <= acc_mag;
                                r_state  <= S_DIV;
                            end
                        end
                        OP_JUMP: r_pc <= r_opd;
                        OP_JNEG: r_pc <= r_acc[15] ? r_opd : r_pc + 7'd1;
                        OP_JZ:   r_pc <= (r_acc == 16'd0) ? r_opd : r_pc + 7'd1;
                        OP_HALT: begin
                            r_flags[F_HALT] <= 1'b1;
                            r_pc            <= 7'd0;
                        end
                        OP_NEG: begin
                            r_acc <= 16'd0 - rd_val;
                            r_pc  <= r_pc + 7'd1;
                        end
                        OP_SUBC: begin
                            r_state <= S_ACCRD;
                        end
                        default: begin
                            // Store, and indirect move through the accumulator.
                            r_pc <= r_pc + 7'd1;
                        end
                    endcase
                end
                S_ACCRD: begin
                    r_acc   <= r_v - rd_val;
                    r_pc    <= r_pc + 7'd1;
                    r_state <= S_OUT;
                end
                S_DIV: begin
                    if (!rem_diff[17]) begin
                        r_rem <= rem_diff[16:0];
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                    if (!r_is_mul) begin
                        r_acc <= q_signed[15:0];
                        r_pc  <= r_pc + 7'd1;
                    end else if ((q_signed + 18'sd1) < signed'({{2{r_v[15]}}, r_v})) begin
                        r_flags[F_OVF]  <= 1'b1;
                        r_flags[F_HALT] <= 1'b1;
                        r_pc            <= 7'd0;
                    end else begin
                        r_acc <= prod[15:0];
                        r_pc  <= r_pc + 7'd1;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || i_m_tready) begin
                        r_o_valid         <= 1'b1;
                        r_out.write_valid <= r_wvalid;
                        r_out.write_value <= r_wv;
                        r_out.acc         <= r_acc;
                        r_out.counter     <= r_pc;
                        r_out.opcode      <= r_opc;
                        r_out.operand     <= r_opd;
                        r_out.flags       <= r_flags;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {6'd0, r_out};

`ifndef NO_ASSERTIONS
    a_reset_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && in_kind == KIND_RESET) |=>
        (r_flags == FLAGS_RESET && r_pc == 7'd0 && r_acc == 16'd0))
        else $error("reset item did not restore the machine state");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_cnt == 4'd0))
        else $error("divider step count left nonzero outside division");
    a_dec_trap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && dec_bad) |=>
        (r_pc == 7'd0 && r_flags[F_DEC] && r_flags[F_HALT]))
        else $error("decode error did not trap");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_FIN))
        else $error("division left early");
`endif

endmodule
